// File: rtl/kpc_pkg.sv
// Shared types, constants and the base decoder of the k-mer prefix counter.
`default_nettype none

package kpc_pkg;

    // 2-bit base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    // ASCII characters that carry a nonzero code
    localparam logic [7:0] ASCII_C_UPPER = 8'h43;
    localparam logic [7:0] ASCII_C_LOWER = 8'h63;
    localparam logic [7:0] ASCII_G_UPPER = 8'h47;
    localparam logic [7:0] ASCII_G_LOWER = 8'h67;
    localparam logic [7:0] ASCII_T_UPPER = 8'h54;
    localparam logic [7:0] ASCII_T_LOWER = 8'h74;

    localparam int unsigned MAX_PREFIX = 16;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] nucleotide;
        logic       last_of_read;
    } kpc_in_t;

    typedef struct packed {
        logic [31:0] prefix_key;
        logic [31:0] occurrences;
        logic        first_seen;
        logic        table_full;
    } kpc_out_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] count;
    } kpc_slot_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } kpc_state_t;

    // A, N and every unknown character decode to BASE_A
    function automatic logic [1:0] base_code(input logic [7:0] ch);
        logic [1:0] code;
        unique case (ch) inside
            ASCII_C_UPPER, ASCII_C_LOWER: code = BASE_C;
            ASCII_G_UPPER, ASCII_G_LOWER: code = BASE_G;
            ASCII_T_UPPER, ASCII_T_LOWER: code = BASE_T;
            default:                      code = BASE_A;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/kmer_prefix_counter.sv
// Top level of the k-mer prefix counter: base packing and the hashed count table.
`default_nettype none

// Channel  | Ports                      | Beat taken when
// ---------+----------------------------+----------------------------------
// input    | start, busy, base_item     | start high and busy low
// result   | done, result               | every cycle with done high
//
// Cycles: one base beat per cycle while busy is low. The beat that ends a
// read starts the table lookup: the slot memory is probed slot after slot
// (1 to TABLE_ENTRIES probes, linear probing), and the result appears with
// done in the cycle after the last probe, when busy is already low again.
// Reset: after rst_n the block sweeps the slot memory once, one slot per
// cycle with busy high, before it takes the first beat.
// The receiver cannot stall: each result stands for exactly one cycle.
module kmer_prefix_counter #(
    parameter int unsigned TABLE_ENTRIES = 4096,
    parameter int unsigned PREFIX_BASES  = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire kpc_pkg::kpc_in_t base_item,
    output logic                  done,
    output kpc_pkg::kpc_out_t     result
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned LIMIT = (PREFIX_BASES > kpc_pkg::MAX_PREFIX) ?
                                    kpc_pkg::MAX_PREFIX : PREFIX_BASES;
    localparam logic [IDX_W:0]   N_EXT     = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] LAST_PRB  = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [4:0]       LIMIT_POS = 5'(LIMIT);

    // (a + b) mod TABLE_ENTRIES for a, b already below TABLE_ENTRIES
    function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= N_EXT) ? IDX_W'(s - N_EXT) : IDX_W'(s);
    endfunction

    // Slot memory: valid, key and count of every slot in one word
    kpc_pkg::kpc_slot_t mem [TABLE_ENTRIES];
    kpc_pkg::kpc_slot_t rd_data_reg;

    kpc_pkg::kpc_state_t state_reg, state_next;

    // Read assembly: position, packed key, key mod table size, and the
    // weights 4^pos and 2*4^pos mod table size for the next base
    logic [4:0]       pos_reg;
    logic [31:0]      key_acc_reg;
    logic [IDX_W-1:0] rem_reg;
    logic [IDX_W-1:0] pw_reg;
    logic [IDX_W-1:0] pw2_reg;

    // Lookup state
    logic [31:0]      probe_key_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] probes_reg;
    logic [IDX_W-1:0] clr_reg;

    logic              done_reg;
    kpc_pkg::kpc_out_t result_reg;
    kpc_pkg::kpc_out_t result_next;

    logic             accept;
    logic             packing;
    logic [1:0]       code;
    logic [31:0]      key_pack;
    logic [IDX_W-1:0] rem_pack;
    logic [IDX_W-1:0] pw4;
    logic [IDX_W-1:0] idx_inc;

    logic             slot_empty;
    logic             slot_hit;
    logic             last_probe;
    logic [31:0]      count_inc;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    kpc_pkg::kpc_slot_t wr_data;
    logic             finish;

    assign accept  = start && !busy;
    assign packing = pos_reg < LIMIT_POS;
    assign code    = kpc_pkg::base_code(base_item.nucleotide);

    // Fold the current base into the key and its remainder
    always_comb
    begin
        key_pack = key_acc_reg;
        rem_pack = rem_reg;
        if (packing)
        begin
            key_pack = key_acc_reg | ({30'd0, code} << {pos_reg[3:0], 1'b0});
            rem_pack = mod_add(mod_add(rem_reg, code[0] ? pw_reg : '0),
                               code[1] ? pw2_reg : '0);
        end
    end

    assign pw4     = mod_add(pw2_reg, pw2_reg);
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    assign slot_empty = !rd_data_reg.valid;
    assign slot_hit   = rd_data_reg.valid && (rd_data_reg.key == probe_key_reg);
    assign last_probe = probes_reg == LAST_PRB;
    assign count_inc  = (rd_data_reg.count == kpc_pkg::COUNT_MAX) ?
                        rd_data_reg.count : rd_data_reg.count + 32'd1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kpc_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_IDX)
                    state_next = kpc_pkg::ST_IDLE;
            end
            kpc_pkg::ST_IDLE:
            begin
                if (accept && base_item.last_of_read)
                    state_next = kpc_pkg::ST_PROBE;
            end
            kpc_pkg::ST_PROBE:
            begin
                if (slot_empty || slot_hit || last_probe)
                    state_next = kpc_pkg::ST_IDLE;
            end
            default: state_next = kpc_pkg::ST_CLEAR;
        endcase
    end

    // Memory control and result
    always_comb
    begin
        busy        = 1'b1;
        rd_en       = 1'b0;
        rd_addr     = rem_pack;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = '{valid: 1'b1, key: probe_key_reg, count: 32'd1};
        finish      = 1'b0;
        result_next = '{prefix_key: probe_key_reg, occurrences: 32'd0,
                        first_seen: 1'b0, table_full: 1'b1};
        unique case (state_reg)
            kpc_pkg::ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '{valid: 1'b0, key: 32'd0, count: 32'd0};
            end
            kpc_pkg::ST_IDLE:
            begin
                busy  = 1'b0;
                rd_en = accept && base_item.last_of_read;
            end
            kpc_pkg::ST_PROBE:
            begin
                if (slot_empty)
                begin
                    // claim the free slot
                    wr_en  = 1'b1;
                    finish = 1'b1;
                    result_next.occurrences = 32'd1;
                    result_next.first_seen  = 1'b1;
                    result_next.table_full  = 1'b0;
                end
                else if (slot_hit)
                begin
                    wr_en         = 1'b1;
                    wr_data.count = count_inc;
                    finish        = 1'b1;
                    result_next.occurrences = count_inc;
                    result_next.table_full  = 1'b0;
                end
                else if (last_probe)
                begin
                    // every slot tried: drop the key
                    finish = 1'b1;
                end
                else
                begin
                    // advance to the next slot
                    rd_en   = 1'b1;
                    rd_addr = idx_inc;
                end
            end
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kpc_pkg::ST_CLEAR;
            pos_reg     <= '0;
            key_acc_reg <= '0;
            rem_reg     <= '0;
            pw_reg      <= IDX_W'(1);
            pw2_reg     <= IDX_W'(2);
            idx_reg     <= '0;
            probes_reg  <= '0;
            clr_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (state_reg == kpc_pkg::ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (accept)
            begin
                if (base_item.last_of_read)
                begin
                    // end of read: hand the key to the lookup, restart packing
                    pos_reg     <= '0;
                    key_acc_reg <= '0;
                    rem_reg     <= '0;
                    pw_reg      <= IDX_W'(1);
                    pw2_reg     <= IDX_W'(2);
                    idx_reg     <= rem_pack;
                    probes_reg  <= '0;
                end
                else if (packing)
                begin
                    pos_reg     <= pos_reg + 5'd1;
                    key_acc_reg <= key_pack;
                    rem_reg     <= rem_pack;
                    pw_reg      <= pw4;
                    pw2_reg     <= mod_add(pw4, pw4);
                end
            end
            else if (state_reg == kpc_pkg::ST_PROBE && rd_en)
            begin
                idx_reg    <= idx_inc;
                probes_reg <= probes_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && base_item.last_of_read)
            probe_key_reg <= key_pack;
        if (finish)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/kpc_checker.sv
// Port-level checks of the k-mer prefix counter and their bind.
`default_nettype none

module kpc_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire kpc_pkg::kpc_in_t  base_item,
    input wire logic              done,
    input wire kpc_pkg::kpc_out_t result
);

    a_new_key_counts_one: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.first_seen |-> result.occurrences == 32'd1 && !result.table_full)
        else $error("new key must report a count of one");

    a_dropped_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.table_full |-> result.occurrences == 32'd0 && !result.first_seen)
        else $error("dropped key must report a zero count");

    a_kept_key_counted: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.table_full |-> result.occurrences != 32'd0)
        else $error("stored key reported with zero count");

    a_lookup_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && base_item.last_of_read |=> busy && !done)
        else $error("end of read must start a lookup");

    a_results_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

endmodule

bind kmer_prefix_counter kpc_checker u_kpc_checker (.*);

`default_nettype wire
